// ----- design/assert_macros.svh -----
// Assertion macros used by the order book top level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OBSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OBSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OBSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define OBSD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- design/obsd_pkg.sv -----
// Types and constants for the order book snapshot and delta builder.
package obsd_pkg;

    localparam int CNT_W = 11;

    localparam logic [2:0] CMD_BEGIN  = 3'd0;
    localparam logic [2:0] CMD_HEADER = 3'd1;
    localparam logic [2:0] CMD_LEVEL  = 3'd2;
    localparam logic [2:0] CMD_END    = 3'd3;
    localparam logic [2:0] CMD_DELTA  = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_STALE      = 3'd1;
    localparam logic [2:0] ST_INVALID    = 3'd2;
    localparam logic [2:0] ST_BAD_SIDE   = 3'd3;
    localparam logic [2:0] ST_NEED_SNAP  = 3'd4;
    localparam logic [2:0] ST_FULL       = 3'd5;
    localparam logic [2:0] ST_UNEXP_LVL  = 3'd6;

    localparam logic [1:0] CFG_BID_CODE  = 2'd0;
    localparam logic [1:0] CFG_ASK_CODE  = 2'd1;
    localparam logic [1:0] CFG_LIVE_CODE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_SET,
        OP_ERASE
    } t_cell_op;

    typedef struct packed {
        logic [2:0]         command;
        logic [7:0]         side;
        logic [31:0]        instrument;
        logic [31:0]        generation;
        logic [7:0]         header_state;
        logic [15:0]        chunk_number;
        logic [15:0]        count;
        logic [15:0]        chunk_total;
        logic signed [63:0] price;
        logic [31:0]        quantity;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        book_live;
        logic        snapshot_open;
        logic [31:0] stored_quantity;
    } t_out_item;

    typedef struct packed {
        t_cell_op         op;
        logic [CNT_W-1:0] cnt;
        logic             tgt_hit;
        logic [63:0]      key;
        logic [31:0]      qty;
    } t_cell_ctl;

    typedef struct packed {
        logic        hit;
        logic [31:0] qty;
    } t_link;

    typedef struct packed {
        logic [63:0] price;
        logic [31:0] qty;
    } t_entry;

endpackage

// ----- design/obsd_cell.sv -----
// One price level slot of a table half: compare, hit chain, set and shift-down erase.
module obsd_cell
    import obsd_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_link     i_link,
    input  t_entry    i_up,
    output t_link     o_link,
    output t_entry    o_ent
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

    logic [63:0] r_price;
    logic [31:0] r_qty;
    logic        w_valid;
    logic        w_hit;

    assign w_valid = MY_IDX < i_ctl.cnt;
    assign w_hit   = w_valid && (r_price == i_ctl.key);

    assign o_link.hit = i_link.hit | w_hit;
    assign o_link.qty = w_hit ? r_qty : i_link.qty;
    assign o_ent.price = r_price;
    assign o_ent.qty   = r_qty;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_SET: begin
                if (w_hit || (!i_ctl.tgt_hit && (MY_IDX == i_ctl.cnt))) begin
                    r_price <= i_ctl.key;
                    r_qty   <= i_ctl.qty;
                end
            end
            OP_ERASE: begin
                if (i_link.hit || w_hit) begin
                    r_price <= i_up.price;
                    r_qty   <= i_up.qty;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- design/order_book_snapshot_delta_builder.sv -----
// Top level: order book snapshot and delta builder with four rows of level cells.
//
//  channel | direction | handshake                     | payload
//  in      | input     | i_in_valid / o_in_stall       | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall     | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_we                      | i_cfg_idx, i_cfg_data
//
// Each transaction is captured, then makes one pass through the cell rows; no new one is taken until then.
// The hit chain across LEVELS_PER_SIDE cells per row sets the critical path.
// The result sits in an output register; a stalled result holds the pass back.
// Synchronous active-low reset empties all table halves at once via fill counts.
module order_book_snapshot_delta_builder
    import obsd_pkg::*;
#(
    parameter int LEVELS_PER_SIDE  = 64,
    parameter int LEVELS_PER_CHUNK = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LEVELS_PER_SIDE);
    localparam logic [16:0]      LPC      = 17'(LEVELS_PER_CHUNK);

    t_state           r_state;
    t_in_item         r_in;
    t_out_item        r_out;
    logic             r_ov;
    logic [7:0]       r_bid, r_ask, r_livec;
    logic             r_bank,   n_bank;
    logic [31:0]      r_inst,   n_inst;
    logic [31:0]      r_gen,    n_gen;
    logic [15:0]      r_explv,  n_explv;
    logic [15:0]      r_expch,  n_expch;
    logic [15:0]      r_rcvlv,  n_rcvlv;
    logic [15:0]      r_rcvch,  n_rcvch;
    logic [15:0]      r_nbid,   n_nbid;
    logic [15:0]      r_nask,   n_nask;
    logic             r_snap,   n_snap;
    logic             r_live,   n_live;
    logic [7:0]       r_pend,   n_pend;
    logic             r_pside,  n_pside;
    logic [CNT_W-1:0] r_cnt [4];
    logic [CNT_W-1:0] n_cnt [4];
    t_out_item        n_out;

    logic             w_go;
    logic             w_side_ok;
    logic             w_sd;
    logic [1:0]       w_hl, w_hs;
    logic             w_hit_l, w_hit_s;
    logic [31:0]      w_q_l, w_q_s;
    t_cell_op         w_op;
    logic             w_tgt_stage;
    t_cell_ctl        w_ctl  [4];
    t_link            w_link [4][LEVELS_PER_SIDE+1];
    t_entry           w_ent  [4][LEVELS_PER_SIDE];

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign w_go        = (r_state == S_EXEC) && (!r_ov || !i_out_stall);

    assign w_side_ok = (r_in.side == r_bid) || (r_in.side == r_ask);
    assign w_sd      = (r_in.side != r_bid);
    assign w_hl      = {r_bank, w_sd};
    assign w_hs      = {~r_bank, (r_in.command == CMD_LEVEL) ? r_pside : w_sd};
    assign w_hit_l   = w_link[w_hl][LEVELS_PER_SIDE].hit;
    assign w_q_l     = w_link[w_hl][LEVELS_PER_SIDE].qty;
    assign w_hit_s   = w_link[w_hs][LEVELS_PER_SIDE].hit;
    assign w_q_s     = w_link[w_hs][LEVELS_PER_SIDE].qty;

    genvar gr, gc;
    generate
        for (gr = 0; gr < 4; gr++) begin : g_row
            assign w_link[gr][0] = '0;
            assign w_ctl[gr].op  = (w_go && (2'(gr) == (w_tgt_stage ? w_hs : w_hl))) ?
                                   w_op : OP_NONE;
            assign w_ctl[gr].cnt = r_cnt[gr];
            assign w_ctl[gr].tgt_hit = w_tgt_stage ? w_hit_s : w_hit_l;
            assign w_ctl[gr].key = $unsigned(r_in.price);
            assign w_ctl[gr].qty = r_in.quantity;
            for (gc = 0; gc < LEVELS_PER_SIDE; gc++) begin : g_cell
                obsd_cell #(.CELL_IDX(gc)) u_cell (
                    .i_clk  (i_clk),
                    .i_ctl  (w_ctl[gr]),
                    .i_link (w_link[gr][gc]),
                    .i_up   (w_ent[gr][(gc == LEVELS_PER_SIDE-1) ? gc : gc+1]),
                    .o_link (w_link[gr][gc+1]),
                    .o_ent  (w_ent[gr][gc])
                );
            end
        end
    endgenerate

    always_comb begin
        logic        clr;
        logic        begin_ok;
        logic [2:0]  st;
        logic [31:0] stored;
        logic [15:0] nxt;
        logic        fail;
        n_bank  = r_bank;
        n_inst  = r_inst;
        n_gen   = r_gen;
        n_explv = r_explv;
        n_expch = r_expch;
        n_rcvlv = r_rcvlv;
        n_rcvch = r_rcvch;
        n_nbid  = r_nbid;
        n_nask  = r_nask;
        n_snap  = r_snap;
        n_live  = r_live;
        n_pend  = r_pend;
        n_pside = r_pside;
        for (int k = 0; k < 4; k++) begin
            n_cnt[k] = r_cnt[k];
        end
        clr         = 1'b0;
        begin_ok    = 1'b0;
        st          = ST_OK;
        stored      = (w_side_ok && w_hit_l) ? w_q_l : 32'd0;
        w_op        = OP_NONE;
        w_tgt_stage = 1'b0;
        nxt         = w_sd ? r_nask : r_nbid;
        fail        = 1'b0;
        case (r_in.command)
            CMD_BEGIN: begin
                if (r_in.generation < r_gen) begin
                    st = ST_STALE;
                end else begin
                    clr      = 1'b1;
                    begin_ok = 1'b1;
                end
            end
            CMD_HEADER: begin
                fail = (r_pend != 8'd0) || !w_side_ok || !r_snap ||
                       (r_in.instrument != r_inst) || (r_in.generation != r_gen) ||
                       (r_in.chunk_number != nxt) || ({1'b0, r_in.count} > LPC) ||
                       (r_rcvch >= r_expch) ||
                       ({1'b0, r_rcvlv} + {1'b0, r_in.count} > {1'b0, r_explv});
                if (fail) begin
                    clr = 1'b1;
                    st  = ST_INVALID;
                end else begin
                    if (w_sd) begin
                        n_nask = r_nask + 16'd1;
                    end else begin
                        n_nbid = r_nbid + 16'd1;
                    end
                    n_rcvch = r_rcvch + 16'd1;
                    n_rcvlv = r_rcvlv + r_in.count;
                    n_pend  = r_in.count[7:0];
                    n_pside = w_sd;
                end
            end
            CMD_LEVEL: begin
                w_tgt_stage = 1'b1;
                stored      = w_hit_s ? w_q_s : 32'd0;
                if (r_pend == 8'd0) begin
                    st = ST_UNEXP_LVL;
                end else if (!w_hit_s && (r_cnt[w_hs] == FULL_CNT)) begin
                    clr = 1'b1;
                    st  = ST_FULL;
                end else begin
                    w_op   = OP_SET;
                    stored = r_in.quantity;
                    n_pend = r_pend - 8'd1;
                    if (!w_hit_s) begin
                        n_cnt[w_hs] = r_cnt[w_hs] + 1'b1;
                    end
                end
            end
            CMD_END: begin
                fail = (r_pend != 8'd0) || !r_snap ||
                       (r_in.instrument != r_inst) || (r_in.generation != r_gen) ||
                       (r_rcvch != r_expch) || (r_rcvlv != r_explv) ||
                       (r_in.count != r_rcvlv);
                if (fail) begin
                    clr = 1'b1;
                    st  = ST_INVALID;
                end else begin
                    n_snap = 1'b0;
                    n_live = (r_in.header_state == r_livec);
                    if (n_live) begin
                        n_bank = ~r_bank;
                        stored = (w_side_ok && w_hit_s) ? w_q_s : 32'd0;
                        for (int k = 0; k < 4; k++) begin
                            if (1'(k >> 1) == r_bank) begin
                                n_cnt[k] = '0;
                            end
                        end
                    end else begin
                        stored = 32'd0;
                        for (int k = 0; k < 4; k++) begin
                            n_cnt[k] = '0;
                        end
                    end
                end
            end
            CMD_DELTA: begin
                if (!w_side_ok) begin
                    st = ST_BAD_SIDE;
                end else if (r_in.generation < r_gen) begin
                    st = ST_STALE;
                end else if ((r_in.generation != r_gen) || !r_live ||
                             (r_in.instrument != r_inst) ||
                             (r_in.header_state != r_livec)) begin
                    n_inst = r_in.instrument;
                    n_gen  = r_in.generation;
                    clr    = 1'b1;
                    st     = ST_NEED_SNAP;
                end else if (r_in.quantity == 32'd0) begin
                    stored = 32'd0;
                    if (w_hit_l) begin
                        w_op        = OP_ERASE;
                        n_cnt[w_hl] = r_cnt[w_hl] - 1'b1;
                    end
                end else if (w_hit_l) begin
                    w_op   = OP_SET;
                    stored = r_in.quantity;
                end else if (r_cnt[w_hl] == FULL_CNT) begin
                    st     = ST_FULL;
                    stored = 32'd0;
                end else begin
                    w_op        = OP_SET;
                    stored      = r_in.quantity;
                    n_cnt[w_hl] = r_cnt[w_hl] + 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (clr) begin
            n_explv = '0;
            n_expch = '0;
            n_rcvlv = '0;
            n_rcvch = '0;
            n_nbid  = '0;
            n_nask  = '0;
            n_snap  = 1'b0;
            n_live  = 1'b0;
            n_pend  = '0;
            n_pside = 1'b0;
            stored  = 32'd0;
            for (int k = 0; k < 4; k++) begin
                n_cnt[k] = '0;
            end
        end
        if (begin_ok) begin
            n_inst  = r_in.instrument;
            n_gen   = r_in.generation;
            n_explv = r_in.count;
            n_expch = r_in.chunk_total;
            n_snap  = 1'b1;
        end
        n_out.status          = st;
        n_out.book_live       = n_live;
        n_out.snapshot_open   = n_snap;
        n_out.stored_quantity = stored;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_bid   <= 8'd0;
            r_ask   <= 8'd1;
            r_livec <= 8'd2;
            r_bank  <= 1'b0;
            r_inst  <= '0;
            r_gen   <= '0;
            r_explv <= '0;
            r_expch <= '0;
            r_rcvlv <= '0;
            r_rcvch <= '0;
            r_nbid  <= '0;
            r_nask  <= '0;
            r_snap  <= 1'b0;
            r_live  <= 1'b0;
            r_pend  <= '0;
            r_pside <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BID_CODE:  r_bid   <= i_cfg_data;
                    CFG_ASK_CODE:  r_ask   <= i_cfg_data;
                    CFG_LIVE_CODE: r_livec <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_go) begin
                r_ov    <= 1'b1;
                r_bank  <= n_bank;
                r_inst  <= n_inst;
                r_gen   <= n_gen;
                r_explv <= n_explv;
                r_expch <= n_expch;
                r_rcvlv <= n_rcvlv;
                r_rcvch <= n_rcvch;
                r_nbid  <= n_nbid;
                r_nask  <= n_nask;
                r_snap  <= n_snap;
                r_live  <= n_live;
                r_pend  <= n_pend;
                r_pside <= n_pside;
                for (int k = 0; k < 4; k++) begin
                    r_cnt[k] <= n_cnt[k];
                end
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_go) begin
            r_out <= n_out;
        end
    end

`include "assert_macros.svh"

    `OBSD_ASSERT(a_cnt_bound, i_clk, i_rst_n, (r_cnt[0] <= FULL_CNT) && (r_cnt[1] <= FULL_CNT) && (r_cnt[2] <= FULL_CNT) && (r_cnt[3] <= FULL_CNT), "table fill count above capacity")
    `OBSD_ASSERT(a_snap_live, i_clk, i_rst_n, !(r_snap && r_live), "book live while snapshot open")
    `OBSD_ASSERT(a_pend_snap, i_clk, i_rst_n, (r_pend != 8'd0) |-> r_snap, "levels pending outside a snapshot")
    `OBSD_ASSERT(a_accept_exec, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC), "accepted transaction not executed")

endmodule

// ----- tb/order_book_snapshot_delta_builder_tb.sv -----
// Testbench for the order book snapshot and delta builder: queued stimulus, book predictor, checker.
module order_book_snapshot_delta_builder_tb;
    import obsd_pkg::*;

    localparam int LPS = 64;
    localparam int LPC = 16;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [7:0] i_cfg_data = '0;

    order_book_snapshot_delta_builder #(.LEVELS_PER_SIDE(LPS), .LEVELS_PER_CHUNK(LPC)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: [bank][side][slot]
    logic [7:0]  bid_code, ask_code, live_code;
    logic [63:0] bk_price [2][2][LPS];
    logic [31:0] bk_qty   [2][2][LPS];
    bit          bk_valid [2][2][LPS];
    bit          live_bank;
    logic [31:0] cur_inst, cur_gen;
    logic [15:0] exp_levels, exp_chunks, rcv_levels, rcv_chunks, nxt_bid, nxt_ask;
    bit          snap_open, book_live;
    logic [7:0]  pend_levels;
    bit          pend_side;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        mismatches = 0;
    int        gap_left = 0, burst_left = 0;
    int        stall_phase = 0;
    bit        hold_off = 0;

    logic [31:0] cur_inst_stim, cur_gen_stim;
    logic [7:0]  bid_stim, ask_stim, live_code_stim;

    function automatic void wipe_bank(bit b);
        for (int s = 0; s < 2; s++)
            for (int i = 0; i < LPS; i++) bk_valid[b][s][i] = 0;
    endfunction

    function automatic void wipe_book();
        exp_levels = 0; exp_chunks = 0; rcv_levels = 0; rcv_chunks = 0;
        nxt_bid = 0; nxt_ask = 0; snap_open = 0; book_live = 0;
        pend_levels = 0; pend_side = 0;
        wipe_bank(0); wipe_bank(1);
    endfunction

    function automatic int slot_of(bit b, bit s, logic [63:0] p);
        for (int i = 0; i < LPS; i++)
            if (bk_valid[b][s][i] && bk_price[b][s][i] == p) return i;
        return -1;
    endfunction

    function automatic int free_slot(bit b, bit s);
        for (int i = 0; i < LPS; i++)
            if (!bk_valid[b][s][i]) return i;
        return -1;
    endfunction

    function automatic t_out_item predict_book(t_in_item it);
        t_out_item r;
        int sd, idx;
        logic [15:0] nxt;
        bit stg;
        logic [2:0] st;
        st = ST_OK; stg = 0;
        sd = (it.side == bid_code) ? 0 : (it.side == ask_code) ? 1 : -1;
        case (it.command)
            CMD_BEGIN: begin
                if (it.generation < cur_gen) st = ST_STALE;
                else begin
                    wipe_book();
                    cur_inst = it.instrument; cur_gen = it.generation;
                    exp_levels = it.count; exp_chunks = it.chunk_total;
                    snap_open = 1;
                end
            end
            CMD_HEADER: begin
                nxt = (sd == 1) ? nxt_ask : nxt_bid;
                if (pend_levels != 0 || sd < 0 || !snap_open || it.instrument != cur_inst ||
                    it.generation != cur_gen || it.chunk_number != nxt || it.count > LPC ||
                    rcv_chunks >= exp_chunks ||
                    32'(rcv_levels) + 32'(it.count) > 32'(exp_levels)) begin
                    wipe_book(); st = ST_INVALID;
                end else begin
                    if (sd == 0) nxt_bid++; else nxt_ask++;
                    rcv_chunks++;
                    rcv_levels += it.count;
                    pend_levels = it.count[7:0];
                    pend_side = sd[0];
                end
            end
            CMD_LEVEL: begin
                stg = 1;
                if (pend_levels == 0) st = ST_UNEXP_LVL;
                else begin
                    idx = slot_of(!live_bank, pend_side, it.price);
                    if (idx < 0) idx = free_slot(!live_bank, pend_side);
                    if (idx < 0) begin
                        wipe_book(); st = ST_FULL;
                    end else begin
                        bk_price[!live_bank][pend_side][idx] = it.price;
                        bk_qty[!live_bank][pend_side][idx] = it.quantity;
                        bk_valid[!live_bank][pend_side][idx] = 1;
                        pend_levels--;
                    end
                end
            end
            CMD_END: begin
                if (pend_levels != 0 || !snap_open || it.instrument != cur_inst ||
                    it.generation != cur_gen || rcv_chunks != exp_chunks ||
                    rcv_levels != exp_levels || it.count != rcv_levels) begin
                    wipe_book(); st = ST_INVALID;
                end else begin
                    snap_open = 0;
                    book_live = (it.header_state == live_code);
                    if (book_live) begin
                        live_bank = !live_bank;
                        wipe_bank(!live_bank);
                    end else begin
                        wipe_bank(0); wipe_bank(1);
                    end
                end
            end
            CMD_DELTA: begin
                if (sd < 0) st = ST_BAD_SIDE;
                else if (it.generation < cur_gen) st = ST_STALE;
                else if (it.generation != cur_gen || !book_live || it.instrument != cur_inst ||
                         it.header_state != live_code) begin
                    cur_inst = it.instrument; cur_gen = it.generation;
                    wipe_book(); st = ST_NEED_SNAP;
                end else begin
                    idx = slot_of(live_bank, sd[0], it.price);
                    if (it.quantity == 0) begin
                        if (idx >= 0) bk_valid[live_bank][sd[0]][idx] = 0;
                    end else begin
                        if (idx < 0) idx = free_slot(live_bank, sd[0]);
                        if (idx < 0) st = ST_FULL;
                        else begin
                            bk_price[live_bank][sd[0]][idx] = it.price;
                            bk_qty[live_bank][sd[0]][idx] = it.quantity;
                            bk_valid[live_bank][sd[0]][idx] = 1;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.status = st;
        r.book_live = book_live;
        r.snapshot_open = snap_open;
        r.stored_quantity = '0;
        if (stg) begin
            idx = slot_of(!live_bank, pend_side, it.price);
            if (idx >= 0) r.stored_quantity = bk_qty[!live_bank][pend_side][idx];
        end else if (sd >= 0) begin
            idx = slot_of(live_bank, sd[0], it.price);
            if (idx >= 0) r.stored_quantity = bk_qty[live_bank][sd[0]][idx];
        end
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(predict_book(i_in_data));
                void'(pending_items.pop_front());
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (hold_off || pending_items.size() == 0 ||
                    (i_in_valid && !o_in_stall && pending_items.size() == 0)) begin
                    i_in_valid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_items[0];
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else burst_left = burst_left - 1;
                end
            end
        end
    end

    // receiver stall pattern and checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", o_out_data);
                end else begin
                    t_out_item e;
                    e = expected_results.pop_front();
                    if (e !== o_out_data) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p actual %p", e, o_out_data);
                    end
                end
            end
            stall_phase = (stall_phase + 1) % 160;
            if (stall_phase < 40) i_out_stall <= 1'b0;
            else if (stall_phase < 100) i_out_stall <= ($urandom_range(0, 3) == 0);
            else i_out_stall <= ($urandom_range(0, 1) == 0);
        end
    end

    function automatic t_in_item blank_item(logic [2:0] cmd);
        t_in_item it;
        it = '0;
        it.command = cmd;
        it.instrument = cur_inst_stim;
        it.generation = cur_gen_stim;
        it.header_state = live_code_stim;
        return it;
    endfunction

    function automatic logic [63:0] rand_price(bit narrow);
        if (narrow) return 64'($signed($urandom_range(0, 40)) - 20);
        return {$urandom, $urandom};
    endfunction

    // queue a well-formed snapshot, with random corruption when corrupt is set
    task automatic queue_snapshot(int bid_chunks, int ask_chunks, bit corrupt, bit go_live);
        t_in_item it;
        int lv[$];
        int total;
        int n;
        total = 0;
        for (int c = 0; c < bid_chunks + ask_chunks; c++) begin
            n = $urandom_range(0, LPC);
            lv.push_back(n);
            total += n;
        end
        if ($urandom_range(0, 3) == 0 && cur_gen_stim < 32'hFFFF_FFF0)
            cur_gen_stim += $urandom_range(1, 3);
        it = blank_item(CMD_BEGIN);
        it.count = 16'(total); it.chunk_total = 16'(bid_chunks + ask_chunks);
        pending_items.push_back(it);
        for (int c = 0; c < bid_chunks + ask_chunks; c++) begin
            it = blank_item(CMD_HEADER);
            it.side = (c < bid_chunks) ? bid_stim : ask_stim;
            it.chunk_number = 16'((c < bid_chunks) ? c : c - bid_chunks);
            it.count = 16'(lv[c]);
            if (corrupt && $urandom_range(0, 9) == 0) it.chunk_number++;
            pending_items.push_back(it);
            for (int l = 0; l < lv[c]; l++) begin
                it = blank_item(CMD_LEVEL);
                it.price = rand_price($urandom_range(0, 3) != 0);
                it.quantity = $urandom;
                pending_items.push_back(it);
            end
        end
        it = blank_item(CMD_END);
        it.count = 16'(total);
        it.header_state = go_live ? live_code_stim : live_code_stim + 8'd1;
        if (corrupt && $urandom_range(0, 2) == 0) it.count++;
        pending_items.push_back(it);
    endtask

    function automatic t_in_item rand_delta();
        t_in_item it;
        it = blank_item(CMD_DELTA);
        it.side = ($urandom_range(0, 1)) ? bid_stim : ask_stim;
        it.price = rand_price($urandom_range(0, 4) != 0);
        it.quantity = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        if ($urandom_range(0, 30) == 0) it.side = 8'($urandom);
        if ($urandom_range(0, 40) == 0) it.generation = cur_gen_stim - 32'd1;
        return it;
    endfunction

    function automatic t_in_item noise_item();
        t_in_item it;
        it = '0;
        it.command = 3'($urandom_range(0, 7));
        it.side = 8'($urandom);
        it.instrument = $urandom;
        it.generation = $urandom;
        it.header_state = 8'($urandom);
        it.chunk_number = 16'($urandom);
        it.count = 16'($urandom);
        it.chunk_total = 16'($urandom);
        it.price = {$urandom, $urandom};
        it.quantity = $urandom;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BID_CODE:  bid_code = val;
            CFG_ASK_CODE:  ask_code = val;
            default:       live_code = val;
        endcase
    endtask

    task automatic set_codes(logic [7:0] b, logic [7:0] a, logic [7:0] l);
        write_reg(CFG_BID_CODE, b);
        write_reg(CFG_ASK_CODE, a);
        write_reg(CFG_LIVE_CODE, l);
        bid_stim = b; ask_stim = a; live_code_stim = l;
    endtask

    initial begin
        t_in_item it;
        bid_code = 0; ask_code = 1; live_code = 2;
        bid_stim = 0; ask_stim = 1; live_code_stim = 2;
        live_bank = 0; cur_inst = 0; cur_gen = 0;
        cur_inst_stim = 32'h1234_5678; cur_gen_stim = 5;
        wipe_book();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: stray level, every command, extremes, bad side, stale, oversized chunk
        it = blank_item(CMD_LEVEL); pending_items.push_back(it);
        it = blank_item(CMD_DELTA); it.side = 8'hFF; pending_items.push_back(it);
        it = blank_item(CMD_DELTA); it.side = bid_stim; pending_items.push_back(it);
        it = blank_item(CMD_END); pending_items.push_back(it);
        it = blank_item(CMD_HEADER); pending_items.push_back(it);
        it = noise_item(); it.command = 3'd7; pending_items.push_back(it);
        queue_snapshot(1, 1, 0, 1);
        it = blank_item(CMD_DELTA); it.side = ask_stim;
        it.price = 64'sh7FFF_FFFF_FFFF_FFFF; it.quantity = '1; pending_items.push_back(it);
        it.price = 64'sh8000_0000_0000_0000; pending_items.push_back(it);
        it.quantity = '0; pending_items.push_back(it);
        it = blank_item(CMD_BEGIN); it.generation = '0; pending_items.push_back(it);
        it = blank_item(CMD_BEGIN); it.generation = '1; it.instrument = '1;
        it.count = '1; it.chunk_total = '1; pending_items.push_back(it);
        it = blank_item(CMD_HEADER); it.generation = '1; it.instrument = '1;
        it.count = 16'(LPC + 1); pending_items.push_back(it);
        wait_drained();

        // fill the bid staging half past its capacity
        cur_gen_stim = 32'hFFFF_FFFF;
        it = blank_item(CMD_BEGIN); it.count = 16'd80; it.chunk_total = 16'd5;
        pending_items.push_back(it);
        for (int c = 0; c < 5; c++) begin
            it = blank_item(CMD_HEADER); it.side = bid_stim; it.chunk_number = 16'(c);
            it.count = 16'(LPC); pending_items.push_back(it);
            for (int l = 0; l < LPC; l++) begin
                it = blank_item(CMD_LEVEL); it.price = 64'(c * LPC + l);
                it.quantity = 32'(l + 1);
                pending_items.push_back(it);
            end
        end
        wait_drained();

        // live table full via deltas
        cur_gen_stim = 32'hFFFF_FFFF;
        queue_snapshot(0, 0, 0, 1);
        for (int l = 0; l < LPS + 2; l++) begin
            it = blank_item(CMD_DELTA); it.side = ask_stim; it.price = 64'(l);
            it.quantity = 32'd7;
            pending_items.push_back(it);
        end
        wait_drained();

        // random phases under different side and live codes
        cur_gen_stim = 32'hFFFF_FFFF;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_codes(8'd0, 8'd255, 8'd255);
                1: set_codes(8'd255, 8'd0, 8'd0);
                2: set_codes(8'd7, 8'd7, 8'd2);
                3: set_codes(8'($urandom), 8'($urandom), 8'($urandom));
                default: set_codes(8'd0, 8'd1, 8'd2);
            endcase
            for (int k = 0; k < 3; k++) begin
                queue_snapshot($urandom_range(0, 3), $urandom_range(0, 3),
                               $urandom_range(0, 4) == 0, $urandom_range(0, 5) != 0);
                repeat ($urandom_range(5, 30)) pending_items.push_back(rand_delta());
                repeat ($urandom_range(0, 3)) pending_items.push_back(noise_item());
            end
            if (ph == 2) begin
                hold_off = 1;
                while (expected_results.size() != 0 || i_in_valid) @(posedge i_clk);
                hold_off = 0;
            end
            wait_drained();
        end
        wait_drained();
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
